[hdl/cba_pkg.sv]
// Shared types and constants for the chunked bump allocator.
// Holds the input/output beat structs, the configuration struct, status codes
// and register indexes. No dependencies.
package cba_pkg;

    // Status codes returned with every result beat
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_OVERFLOW    = 3'd1;
    localparam logic [2:0] ST_REQ_LIMIT   = 3'd2;
    localparam logic [2:0] ST_CHUNK_LIMIT = 3'd3;
    localparam logic [2:0] ST_TOTAL_LIMIT = 3'd4;
    localparam logic [2:0] ST_ZERO        = 3'd5;

    // Input op codes
    localparam logic OP_ALLOC    = 1'b0;
    localparam logic OP_FREE_ALL = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_REQUEST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOTAL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROWTH      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CHUNK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNK   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT   = 3'd5;

    // Reset values of the configuration registers
    localparam logic [15:0] GROWTH_RESET    = 16'd2560;
    localparam logic [31:0] MIN_CHUNK_RESET = 32'd10;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [31:0] U32_MAX   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        op;
        logic [31:0] elem_count;
        logic [31:0] elem_bytes;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  status;
        logic        opened_chunk;
        logic [15:0] chunk_number;
        logic [31:0] chunk_offset;
        logic [31:0] chunk_bytes;
        logic [31:0] bytes_in_use;
        logic [31:0] bytes_reserved;
    } t_out_beat;

    typedef struct packed {
        logic [31:0] max_request_bytes;
        logic [31:0] max_total_bytes;
        logic [15:0] growth_factor;
        logic [31:0] min_chunk_bytes;
        logic [31:0] max_chunk_bytes;
        logic [15:0] max_chunk_count;
    } t_cfg;

endpackage

[hdl/chunked_bump_allocator_core.sv]
// Top level of the chunked bump allocator: configuration registers,
// input handshake and output register. Depends on cba_pkg, cba_engine, cba_mul.
//
//   channel   direction  handshake                   payload
//   in        input      i_in_valid / o_in_stall     i_in_beat  (op, count, bytes)
//   out       output     o_out_valid / i_out_stall   o_out_beat (status, chunk, totals)
//   cfg       input      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// A free-all beat goes from IDLE straight to DONE, a request rejected by its size checks
// passes MUL1 and CHK, one that fits the head chunk also FIT, and one that opens a chunk
// also MUL2, GROW, CLAMP and TOT. The shared 32x32 multiplier is used twice in sequence
// and each compare step has its own state. Reset (synchronous, active low) empties the
// arena and restores register defaults. A result waits in the output register while
// stalled; the next beat is taken meanwhile and holds in its last step, DONE, until the register frees.
module chunked_bump_allocator_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  cba_pkg::t_in_beat                 i_in_beat,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output cba_pkg::t_out_beat                o_out_beat,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cba_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);

    cba_pkg::t_cfg      r_cfg, n_cfg;
    logic               r_out_valid, n_out_valid;
    cba_pkg::t_out_beat r_out_beat, n_out_beat;

    logic               eng_idle;
    logic               eng_res_valid;
    cba_pkg::t_out_beat eng_res;
    logic               res_take;
    logic               in_accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !eng_idle;
    assign in_accept   = i_in_valid && eng_idle;
    assign res_take    = eng_res_valid && (!r_out_valid || !i_out_stall);

    cba_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_start     (in_accept),
        .i_item      (i_in_beat),
        .i_res_take  (res_take),
        .o_idle      (eng_idle),
        .o_res_valid (eng_res_valid),
        .o_res       (eng_res)
    );

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cba_pkg::CFG_MAX_REQUEST: n_cfg.max_request_bytes = i_cfg_data;
                cba_pkg::CFG_MAX_TOTAL:   n_cfg.max_total_bytes   = i_cfg_data;
                cba_pkg::CFG_GROWTH:      n_cfg.growth_factor     = i_cfg_data[15:0];
                cba_pkg::CFG_MIN_CHUNK:   n_cfg.min_chunk_bytes   = i_cfg_data;
                cba_pkg::CFG_MAX_CHUNK:   n_cfg.max_chunk_bytes   = i_cfg_data;
                cba_pkg::CFG_MAX_COUNT:   n_cfg.max_chunk_count   = i_cfg_data[15:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_beat  = r_out_beat;
        if (res_take) begin
            n_out_valid = 1'b1;
            n_out_beat  = eng_res;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_request_bytes <= '0;
            r_cfg.max_total_bytes   <= '0;
            r_cfg.growth_factor     <= cba_pkg::GROWTH_RESET;
            r_cfg.min_chunk_bytes   <= cba_pkg::MIN_CHUNK_RESET;
            r_cfg.max_chunk_bytes   <= '0;
            r_cfg.max_chunk_count   <= '0;
            r_out_valid             <= 1'b0;
        end else begin
            r_cfg       <= n_cfg;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_beat <= n_out_beat;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

[hdl/cba_mul.sv]
// Shared 32x32 unsigned multiplier with a registered product.
// Used for both the request size and the chunk growth product. Uses no package.
module cba_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_p;
    logic [63:0] n_p;

    assign n_p = {32'b0, i_a} * {32'b0, i_b};

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;

endmodule

[hdl/cba_engine.sv]
// Allocation sequencer: request checks, fit test, chunk growth and limits.
// Depends on cba_pkg and drives one shared cba_mul instance.
module cba_engine (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cba_pkg::t_cfg         i_cfg,
    input  logic                  i_start,
    input  cba_pkg::t_in_beat     i_item,
    input  logic                  i_res_take,
    output logic                  o_idle,
    output logic                  o_res_valid,
    output cba_pkg::t_out_beat    o_res
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL1  = 9'b000000010,
        S_CHK   = 9'b000000100,
        S_FIT   = 9'b000001000,
        S_MUL2  = 9'b000010000,
        S_GROW  = 9'b000100000,
        S_CLAMP = 9'b001000000,
        S_TOT   = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    typedef struct packed {
        logic [2:0]  status;
        logic        opened;
        logic [15:0] num;
        logic [31:0] off;
        logic [31:0] cb;
    } t_res;

    function automatic t_res fail_res(input logic [2:0] code);
        t_res r;
        r        = '0;
        r.status = code;
        return r;
    endfunction

    t_state      r_state, n_state;
    logic [31:0] r_cnt, n_cnt;
    logic [31:0] r_eb, n_eb;
    logic [31:0] r_req, n_req;
    logic [31:0] r_size, n_size;
    t_res        r_res, n_res;
    logic [31:0] r_head_used, n_head_used;
    logic [31:0] r_head_limit, n_head_limit;
    logic [15:0] r_chunk_count, n_chunk_count;
    logic [31:0] r_reserved, n_reserved;
    logic [31:0] r_used, n_used;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [31:0] room;
    logic [39:0] grown;
    logic [31:0] sat;
    logic [31:0] capped;
    logic [32:0] tot;

    assign mul_a = (r_state == S_MUL2) ? r_req : r_cnt;
    assign mul_b = (r_state == S_MUL2) ? {16'b0, i_cfg.growth_factor} : r_eb;

    cba_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign room   = r_head_limit - r_head_used;
    assign grown  = mul_p[47:8];
    assign sat    = (|grown[39:32]) ? cba_pkg::U32_MAX : grown[31:0];
    assign capped = (i_cfg.max_chunk_bytes != 32'd0 && r_size > i_cfg.max_chunk_bytes)
                    ? i_cfg.max_chunk_bytes : r_size;
    assign tot    = {1'b0, r_reserved} + {1'b0, r_size};

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_eb          = r_eb;
        n_req         = r_req;
        n_size        = r_size;
        n_res         = r_res;
        n_head_used   = r_head_used;
        n_head_limit  = r_head_limit;
        n_chunk_count = r_chunk_count;
        n_reserved    = r_reserved;
        n_used        = r_used;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cnt = i_item.elem_count;
                    n_eb  = i_item.elem_bytes;
                    if (i_item.op == cba_pkg::OP_FREE_ALL) begin
                        n_head_used   = '0;
                        n_head_limit  = '0;
                        n_chunk_count = '0;
                        n_reserved    = '0;
                        n_used        = '0;
                        n_res         = fail_res(cba_pkg::ST_OK);
                        n_state       = S_DONE;
                    end else begin
                        n_state = S_MUL1;
                    end
                end
            end
            S_MUL1: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                n_req = mul_p[31:0];
                priority if (|mul_p[63:32]) begin
                    n_res   = fail_res(cba_pkg::ST_OVERFLOW);
                    n_state = S_DONE;
                end else if (mul_p[31:0] == 32'd0) begin
                    n_res   = fail_res(cba_pkg::ST_ZERO);
                    n_state = S_DONE;
                end else if (i_cfg.max_request_bytes != 32'd0 &&
                             mul_p[31:0] > i_cfg.max_request_bytes) begin
                    n_res   = fail_res(cba_pkg::ST_REQ_LIMIT);
                    n_state = S_DONE;
                end else begin
                    n_state = S_FIT;
                end
            end
            S_FIT: begin
                if (r_chunk_count != 16'd0 && r_head_used <= r_head_limit &&
                    r_req <= room) begin
                    // bump inside the head chunk
                    n_head_used = r_head_used + r_req;
                    n_used      = r_used + r_req;
                    n_res       = '{status: cba_pkg::ST_OK, opened: 1'b0,
                                    num: r_chunk_count - 16'd1,
                                    off: r_head_used, cb: r_head_limit};
                    n_state     = S_DONE;
                end else begin
                    n_state = S_MUL2;
                end
            end
            S_MUL2: begin
                n_state = S_GROW;
            end
            S_GROW: begin
                // saturate the 8.8 product, then raise to the minimum
                n_size  = (sat < i_cfg.min_chunk_bytes) ? i_cfg.min_chunk_bytes : sat;
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                n_size  = (capped < r_req) ? r_req : capped;
                n_state = S_TOT;
            end
            S_TOT: begin
                priority if ((i_cfg.max_chunk_count != 16'd0 &&
                              r_chunk_count >= i_cfg.max_chunk_count) ||
                             r_chunk_count == cba_pkg::COUNT_MAX) begin
                    n_res = fail_res(cba_pkg::ST_CHUNK_LIMIT);
                end else if (tot[32] || (i_cfg.max_total_bytes != 32'd0 &&
                                         tot[31:0] > i_cfg.max_total_bytes)) begin
                    n_res = fail_res(cba_pkg::ST_TOTAL_LIMIT);
                end else begin
                    // open a new head chunk and place the request at offset 0
                    n_reserved    = tot[31:0];
                    n_chunk_count = r_chunk_count + 16'd1;
                    n_head_limit  = r_size;
                    n_head_used   = r_req;
                    n_used        = r_used + r_req;
                    n_res         = '{status: cba_pkg::ST_OK, opened: 1'b1,
                                      num: r_chunk_count, off: 32'd0, cb: r_size};
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_head_used   <= '0;
            r_head_limit  <= '0;
            r_chunk_count <= '0;
            r_reserved    <= '0;
            r_used        <= '0;
        end else begin
            r_state       <= n_state;
            r_head_used   <= n_head_used;
            r_head_limit  <= n_head_limit;
            r_chunk_count <= n_chunk_count;
            r_reserved    <= n_reserved;
            r_used        <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_eb   <= n_eb;
        r_req  <= n_req;
        r_size <= n_size;
        r_res  <= n_res;
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res                = '0;
        o_res.status         = r_res.status;
        o_res.opened_chunk   = r_res.opened;
        o_res.chunk_number   = r_res.num;
        o_res.chunk_offset   = r_res.off;
        o_res.chunk_bytes    = r_res.cb;
        o_res.bytes_in_use   = r_used;
        o_res.bytes_reserved = r_reserved;
    end

`ifndef SYNTHESIS
    a_head_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head_used <= r_head_limit)
        else $error("head chunk used bytes exceed its size");

    a_used_within_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= r_reserved)
        else $error("bytes in use exceed bytes reserved");

    a_empty_arena: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_chunk_count == 16'd0) |-> (r_reserved == 32'd0 && r_head_limit == 32'd0))
        else $error("no chunk open but bytes reserved");

    a_take_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_take) |=> o_idle)
        else $error("sequencer did not return to idle after result handoff");
`endif

endmodule

[tb/sv/cba_scoreboard_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard for the chunked bump allocator testbench: a cycle-free predictor
// of the arena and its limits, plus the check of result beats. Depends on cba_pkg.
package cba_scoreboard_pkg;

    import cba_pkg::*;

    class arena_scoreboard;

        // register copies
        logic [31:0] max_request;
        logic [31:0] max_total;
        logic [15:0] growth;
        logic [31:0] min_chunk;
        logic [31:0] max_chunk;
        logic [15:0] max_count;

        // arena state
        logic [31:0] head_used;
        logic [31:0] head_limit;
        logic [15:0] chunk_count;
        logic [31:0] reserved_total;
        logic [31:0] used_total;

        t_out_beat   predicted_allocs[$];
        int unsigned mismatches;
        int unsigned results_seen;

        function new();
            max_request  = '0;
            max_total    = '0;
            growth       = GROWTH_RESET;
            min_chunk    = MIN_CHUNK_RESET;
            max_chunk    = '0;
            max_count    = '0;
            mismatches   = 0;
            results_seen = 0;
            clear_arena();
        endfunction

        function void clear_arena();
            head_used      = '0;
            head_limit     = '0;
            chunk_count    = '0;
            reserved_total = '0;
            used_total     = '0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                CFG_MAX_REQUEST: max_request = data;
                CFG_MAX_TOTAL:   max_total   = data;
                CFG_GROWTH:      growth      = data[15:0];
                CFG_MIN_CHUNK:   min_chunk   = data;
                CFG_MAX_CHUNK:   max_chunk   = data;
                CFG_MAX_COUNT:   max_count   = data[15:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return predicted_allocs.size();
        endfunction

        // Predict the result of one accepted request and queue it.
        function void note_request(t_in_beat b);
            t_out_beat   r;
            logic [63:0] prod;
            logic [63:0] grown;
            logic [32:0] total;
            logic [31:0] req;
            logic [31:0] size;
            r = '0;
            r.status = ST_OK;
            if (b.op == OP_FREE_ALL) begin
                clear_arena();
            end else begin
                prod = {32'b0, b.elem_count} * {32'b0, b.elem_bytes};
                req  = prod[31:0];
                if (prod[63:32] != '0) begin
                    r.status = ST_OVERFLOW;
                end else if (req == '0) begin
                    r.status = ST_ZERO;
                end else if (max_request != '0 && req > max_request) begin
                    r.status = ST_REQ_LIMIT;
                end else if (chunk_count != '0 && head_used <= head_limit &&
                             req <= head_limit - head_used) begin
                    r.chunk_number = chunk_count - 16'd1;
                    r.chunk_offset = head_used;
                    r.chunk_bytes  = head_limit;
                    head_used  += req;
                    used_total += req;
                end else begin
                    grown = ({32'b0, req} * {48'b0, growth}) >> 8;
                    size  = (grown[63:32] != '0) ? U32_MAX : grown[31:0];
                    if (size < min_chunk)
                        size = min_chunk;
                    if (max_chunk != '0 && size > max_chunk)
                        size = max_chunk;
                    if (size < req)
                        size = req;
                    total = {1'b0, reserved_total} + {1'b0, size};
                    if ((max_count != '0 && chunk_count >= max_count) ||
                        chunk_count == COUNT_MAX) begin
                        r.status = ST_CHUNK_LIMIT;
                    end else if (total[32] || (max_total != '0 && total[31:0] > max_total)) begin
                        r.status = ST_TOTAL_LIMIT;
                    end else begin
                        reserved_total = total[31:0];
                        r.opened_chunk = 1'b1;
                        r.chunk_number = chunk_count;
                        r.chunk_bytes  = size;
                        chunk_count += 16'd1;
                        head_limit  = size;
                        head_used   = req;
                        used_total += req;
                    end
                end
            end
            r.bytes_in_use   = used_total;
            r.bytes_reserved = reserved_total;
            predicted_allocs.push_back(r);
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 40)
                $display("mismatch at result %0d: %s", results_seen, msg);
        endtask

        task check_result(t_out_beat got);
            t_out_beat want;
            if (predicted_allocs.size() == 0) begin
                report($sformatf("result beat with nothing pending, status %0d", got.status));
                results_seen++;
                return;
            end
            want = predicted_allocs.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.opened_chunk !== want.opened_chunk)
                report($sformatf("opened_chunk %0d, want %0d",
                                 got.opened_chunk, want.opened_chunk));
            if (got.chunk_number !== want.chunk_number)
                report($sformatf("chunk_number %0d, want %0d",
                                 got.chunk_number, want.chunk_number));
            if (got.chunk_offset !== want.chunk_offset)
                report($sformatf("chunk_offset %0h, want %0h",
                                 got.chunk_offset, want.chunk_offset));
            if (got.chunk_bytes !== want.chunk_bytes)
                report($sformatf("chunk_bytes %0h, want %0h",
                                 got.chunk_bytes, want.chunk_bytes));
            if (got.bytes_in_use !== want.bytes_in_use)
                report($sformatf("bytes_in_use %0h, want %0h",
                                 got.bytes_in_use, want.bytes_in_use));
            if (got.bytes_reserved !== want.bytes_reserved)
                report($sformatf("bytes_reserved %0h, want %0h",
                                 got.bytes_reserved, want.bytes_reserved));
            results_seen++;
        endtask

        task flush_leftover();
            if (predicted_allocs.size() != 0)
                report($sformatf("%0d results never arrived", predicted_allocs.size()));
        endtask

    endclass

endpackage

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Top-level testbench of chunked_bump_allocator_core: directed and random
// allocation traffic with bursty input and stalling output. Depends on cba_pkg
// and cba_scoreboard_pkg.
module tb;

    import cba_pkg::*;
    import cba_scoreboard_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 4_000_000;
    localparam int unsigned DRAIN_LIMIT     = 20_000;
    localparam int unsigned SETTLE_CYCLES   = 12;
    localparam int unsigned HOLD_CYCLES     = 400;
    localparam int unsigned RANDOM_PHASES   = 8;
    localparam int unsigned ITEMS_PER_PHASE = 225;
    localparam int unsigned CHAIN_ITEMS     = 64;

    // indexes that map to no register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_beat             i_in_beat;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_beat            o_out_beat;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]          i_cfg_data;

    arena_scoreboard sb = new();

    int unsigned cycle_count = 0;
    int unsigned burst_left  = 0;
    bit          tx_gapless  = 1'b0;
    bit          rx_quiet    = 1'b0;
    bit          hold_request = 1'b0;

    chunked_bump_allocator_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out_beat);
    end

    // Output stall pattern; a requested hold keeps the result register full.
    initial begin
        t_rx_mode    mode;
        int unsigned mode_left;
        int unsigned period;
        int unsigned held;
        mode        = RX_OPEN;
        mode_left   = 0;
        period      = 2;
        held        = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && held == 0) begin
                held         = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (held != 0) begin
                held--;
                i_out_stall <= 1'b1;
            end else if (rx_quiet) begin
                i_out_stall <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 300);
                    period    = $urandom_range(2, 7);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:  i_out_stall <= 1'b0;
                    RX_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default:  i_out_stall <= (mode_left % period == 0);
                endcase
            end
        end
    end

    function automatic t_in_beat make_beat(logic op, logic [31:0] cnt, logic [31:0] bytes);
        t_in_beat b;
        b.op         = op;
        b.elem_count = cnt;
        b.elem_bytes = bytes;
        return b;
    endfunction

    // Offer one beat in the current burst; called and returns at a falling edge.
    task automatic offer(t_in_beat b);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = (tx_gapless || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(b);
        @(negedge i_clk);
    endtask

    task automatic drain();
        int unsigned n;
        n = 0;
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0 && n < DRAIN_LIMIT) begin
            @(negedge i_clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Leave valid high so back-to-back writes need no toggle.
    task automatic put_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_register(idx, data);
        @(negedge i_clk);
    endtask

    task automatic apply_config(t_cfg c);
        put_register(CFG_MAX_REQUEST, c.max_request_bytes);
        put_register(CFG_MAX_TOTAL, c.max_total_bytes);
        put_register(CFG_GROWTH, {16'($urandom), c.growth_factor});
        put_register(CFG_MIN_CHUNK, c.min_chunk_bytes);
        put_register(CFG_MAX_CHUNK, c.max_chunk_bytes);
        put_register(CFG_MAX_COUNT, {16'($urandom), c.max_chunk_count});
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_value(logic [31:0] low_end, logic [31:0] typical);
        case ($urandom_range(0, 5))
            0:       return low_end;
            1:       return U32_MAX;
            2:       return $urandom;
            default: return typical;
        endcase
    endfunction

    function automatic t_cfg random_config();
        t_cfg c;
        c.max_request_bytes = pick_value(32'd0, $urandom_range(1, 8192));
        c.max_total_bytes   = pick_value(32'd0, $urandom_range(1000, 200_000));
        c.min_chunk_bytes   = pick_value(32'd1, $urandom_range(1, 4096));
        c.max_chunk_bytes   = pick_value(32'd0, $urandom_range(16, 65536));
        case ($urandom_range(0, 3))
            0:       c.growth_factor = 16'($urandom_range(0, 255));
            1:       c.growth_factor = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'($urandom);
            default: c.growth_factor = 16'($urandom_range(256, 4096));
        endcase
        case ($urandom_range(0, 4))
            0:       c.max_chunk_count = '0;
            1:       c.max_chunk_count = COUNT_MAX;
            2:       c.max_chunk_count = 16'($urandom);
            default: c.max_chunk_count = 16'($urandom_range(1, 8));
        endcase
        return c;
    endfunction

    // Mostly small requests that walk the arena through its chunks.
    function automatic t_in_beat random_item();
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 5)
            return make_beat(OP_FREE_ALL, $urandom, $urandom);
        if (k < 10)
            return make_beat(OP_ALLOC, $urandom, $urandom);
        if (k < 15)
            return ($urandom_range(0, 1) == 0) ? make_beat(OP_ALLOC, 32'd0, $urandom)
                                                : make_beat(OP_ALLOC, $urandom, 32'd0);
        if (k < 22)
            return ($urandom_range(0, 1) == 0) ? make_beat(OP_ALLOC, 32'd1, $urandom)
                                                : make_beat(OP_ALLOC, $urandom, 32'd1);
        if (k < 30)
            return make_beat(OP_ALLOC, 32'd1, $urandom_range(1, 70_000));
        return make_beat(OP_ALLOC, $urandom_range(1, 64), $urandom_range(1, 128));
    endfunction

    initial begin
        t_cfg        c;
        int unsigned p;
        int unsigned i;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_beat   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: growth 10x, smallest chunk 10, no limits.
        offer(make_beat(OP_FREE_ALL, 32'd0, 32'd0));
        offer(make_beat(OP_ALLOC, 32'd1, 32'd1));
        offer(make_beat(OP_ALLOC, 32'd3, 32'd3));                 // exact fit
        offer(make_beat(OP_ALLOC, 32'd1, 32'd1));
        offer(make_beat(OP_ALLOC, U32_MAX, U32_MAX));
        offer(make_beat(OP_ALLOC, 32'h1_0000, 32'h1_0000));       // product just past 32 bits
        offer(make_beat(OP_ALLOC, U32_MAX, 32'd1));               // total wraps
        offer(make_beat(OP_ALLOC, 32'd0, 32'd5));
        offer(make_beat(OP_ALLOC, 32'd7, 32'd0));
        offer(make_beat(OP_FREE_ALL, U32_MAX, U32_MAX));
        offer(make_beat(OP_ALLOC, U32_MAX, 32'd1));               // saturated growth
        offer(make_beat(OP_ALLOC, 32'd1, 32'd1));
        drain();

        put_register(CFG_SPARE_A, $urandom);
        put_register(CFG_SPARE_B, $urandom);
        c = '{max_request_bytes: 32'd100, max_total_bytes: 32'd1000, growth_factor: 16'd128,
              min_chunk_bytes: 32'd1, max_chunk_bytes: 32'd50, max_chunk_count: 16'd2};
        apply_config(c);
        offer(make_beat(OP_ALLOC, 32'd101, 32'd1));
        offer(make_beat(OP_ALLOC, 32'd100, 32'd1));               // clamp below request
        offer(make_beat(OP_ALLOC, 32'd10, 32'd10));
        offer(make_beat(OP_ALLOC, 32'd1, 32'd1));                 // chunk limit
        offer(make_beat(OP_FREE_ALL, 32'd0, 32'd0));
        drain();

        c = '{max_request_bytes: 32'd0, max_total_bytes: 32'd150, growth_factor: 16'd256,
              min_chunk_bytes: 32'd1, max_chunk_bytes: 32'd0, max_chunk_count: 16'd0};
        apply_config(c);
        offer(make_beat(OP_ALLOC, 32'd100, 32'd1));
        offer(make_beat(OP_ALLOC, 32'd60, 32'd1));                // total limit
        offer(make_beat(OP_ALLOC, 32'd50, 32'd1));                // total met exactly
        drain();

        // Open one-byte chunks back to back with the output never stalled.
        c = '{max_request_bytes: 32'd0, max_total_bytes: 32'd0, growth_factor: 16'd256,
              min_chunk_bytes: 32'd1, max_chunk_bytes: 32'd1, max_chunk_count: 16'd0};
        apply_config(c);
        rx_quiet   = 1'b1;
        tx_gapless = 1'b1;
        offer(make_beat(OP_FREE_ALL, 32'd0, 32'd0));
        for (i = 0; i < CHAIN_ITEMS; i++)
            offer(make_beat(OP_ALLOC, 32'd1, 32'd1));
        offer(make_beat(OP_FREE_ALL, 32'd0, 32'd0));
        drain();
        rx_quiet   = 1'b0;
        tx_gapless = 1'b0;

        for (p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0)
                c = '{max_request_bytes: 32'd0, max_total_bytes: 32'd0, growth_factor: 16'd0,
                      min_chunk_bytes: 32'd1, max_chunk_bytes: 32'd0, max_chunk_count: 16'd0};
            else if (p == 1)
                c = '{max_request_bytes: U32_MAX, max_total_bytes: U32_MAX,
                      growth_factor: 16'hFFFF, min_chunk_bytes: U32_MAX,
                      max_chunk_bytes: U32_MAX, max_chunk_count: COUNT_MAX};
            else
                c = random_config();
            apply_config(c);
            if (p == 2)
                hold_request = 1'b1;
            for (i = 0; i < ITEMS_PER_PHASE; i++)
                offer(random_item());
            drain();
        end

        sb.flush_leftover();
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
hdl/cba_pkg.sv
hdl/cba_mul.sv
hdl/cba_engine.sv
hdl/chunked_bump_allocator_core.sv
tb/sv/cba_scoreboard_pkg.sv
tb/sv/tb.sv
